/* design/hrc_pkg.sv */
// shared types and fixed-point constants for the humidity and temperature conversion
`default_nettype none
package hrc_pkg;

    // raw field widths
    localparam int unsigned TEMP_WORD_W = 16;
    localparam int unsigned RH_WORD_W   = 16;

    // result widths
    localparam int unsigned TEMP_W = 15;
    localparam int unsigned LIN_W  = 18;
    localparam int unsigned COMP_W = 19;

    // internal widths
    localparam int unsigned R16_W   = 13;
    localparam int unsigned SQ_W    = 25;
    localparam int unsigned LR_W    = 42;
    localparam int unsigned LIN32_W = 44;
    localparam int unsigned K_W     = 35;
    localparam int unsigned PROD_W  = 50;
    localparam int unsigned ACC_W   = 52;

    // offsets in raw counts
    localparam logic signed [TEMP_W-1:0] TEMP_OFS = 15'sd1600;
    localparam logic signed [R16_W-1:0]  RH_OFS   = 13'sd384;
    localparam logic signed [TEMP_W:0]   TEMP_REF = 16'sd960;

    // coefficients with 24 fractional bits
    localparam logic signed [17:0] COEF_A = 18'sd65934;
    // 2^28 - 16*B folded into one factor on r
    localparam logic signed [28:0] COEF_R = 29'sd160846528;
    // 256*C
    localparam logic signed [LIN32_W-1:0] COEF_C256 = 44'sd20548841472;
    localparam logic signed [17:0] COEF_D = 18'sd39762;
    // 256*E
    localparam logic signed [K_W-1:0] COEF_E256 = 35'sd847397120;

    // rounding shifts
    localparam int unsigned LIN_SH  = 24;
    localparam int unsigned COMP_SH = 29;

    // saturation bounds
    localparam logic signed [LIN_W-1:0]  LIN_MIN  = -18'sd4096;
    localparam logic signed [LIN_W-1:0]  LIN_MAX  = 18'sd131071;
    localparam logic signed [COMP_W-1:0] COMP_MIN = -19'sd16384;
    localparam logic signed [COMP_W-1:0] COMP_MAX = 19'sd262143;

    // what the linearization half hands to the compensation half
    typedef struct packed {
        logic                     valid;
        logic signed [TEMP_W-1:0] temp;
        logic signed [LIN_W-1:0]  lin;
    } t_lin_out;

endpackage
`default_nettype wire

/* design/hrc_lin.sv */
// offset removal, quadratic linearization and rounding of humidity, four stages
`default_nettype none
module hrc_lin (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_en,
    input  wire logic                              i_valid,
    input  wire logic [hrc_pkg::TEMP_WORD_W-1:0]   i_temp_word,
    input  wire logic [hrc_pkg::RH_WORD_W-1:0]     i_rh_word,
    output hrc_pkg::t_lin_out                      o_res
);
    import hrc_pkg::*;

    localparam int unsigned QL_W = LIN32_W - LIN_SH + 1;

    // stage 1
    logic                     r_v1;
    logic signed [TEMP_W-1:0] r_t1;
    logic signed [R16_W-1:0]  r_r1;
    logic signed [TEMP_W-1:0] n_t1;
    logic signed [R16_W-1:0]  n_r1;

    // stage 2
    logic                     r_v2;
    logic signed [TEMP_W-1:0] r_t2;
    logic signed [SQ_W-1:0]   r_sq2;
    logic signed [LR_W-1:0]   r_lr2;
    logic signed [SQ_W-1:0]   n_sq2;
    logic signed [LR_W-1:0]   n_lr2;

    // stage 3
    logic                       r_v3;
    logic signed [TEMP_W-1:0]   r_t3;
    logic signed [LIN32_W-1:0]  r_l3;
    logic signed [LIN32_W-1:0]  n_l3;
    logic signed [LIN32_W-1:0]  asq;

    // stage 4
    logic                     r_v4;
    logic signed [TEMP_W-1:0] r_t4;
    logic signed [LIN_W-1:0]  r_lin4;
    logic signed [LIN_W-1:0]  n_lin4;
    logic                     neg;
    logic [LIN32_W-1:0]       mag;
    logic [LIN32_W-1:0]       mag_r;
    logic signed [QL_W-1:0]   q;

    always_comb begin
        n_t1 = $signed({1'b0, i_temp_word[TEMP_WORD_W-1:2]}) - TEMP_OFS;
        n_r1 = $signed({1'b0, i_rh_word[RH_WORD_W-1:4]}) - RH_OFS;
    end

    always_comb begin
        n_sq2 = SQ_W'(SQ_W'(r_r1) * SQ_W'(r_r1));
        n_lr2 = LR_W'(LR_W'(r_r1) * LR_W'(COEF_R));
    end

    always_comb begin
        asq  = LIN32_W'(LIN32_W'(r_sq2) * LIN32_W'(COEF_A));
        n_l3 = asq + LIN32_W'(r_lr2) + COEF_C256;
    end

    // round to nearest with ties away from zero, then saturate
    always_comb begin
        neg   = r_l3[LIN32_W-1];
        mag   = neg ? LIN32_W'(-r_l3) : LIN32_W'(r_l3);
        mag_r = (mag + (LIN32_W'(1) << (LIN_SH - 1))) >> LIN_SH;
        q     = neg ? -$signed(QL_W'(mag_r)) : $signed(QL_W'(mag_r));
        if (q < QL_W'(LIN_MIN)) begin
            n_lin4 = LIN_MIN;
        end else if (q > QL_W'(LIN_MAX)) begin
            n_lin4 = LIN_MAX;
        end else begin
            n_lin4 = LIN_W'(q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t1   <= n_t1;
            r_r1   <= n_r1;
            r_t2   <= r_t1;
            r_sq2  <= n_sq2;
            r_lr2  <= n_lr2;
            r_t3   <= r_t2;
            r_l3   <= n_l3;
            r_t4   <= r_t3;
            r_lin4 <= n_lin4;
        end
    end

    assign o_res.valid = r_v4;
    assign o_res.temp  = r_t4;
    assign o_res.lin   = r_lin4;

endmodule
`default_nettype wire

/* design/hrc_comp.sv */
// temperature compensation of linearized humidity, three stages ending in the output register
`default_nettype none
module hrc_comp (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_en,
    input  wire hrc_pkg::t_lin_out                   i_res,
    output logic                                     o_valid,
    output logic signed [hrc_pkg::TEMP_W-1:0]        o_temp,
    output logic signed [hrc_pkg::LIN_W-1:0]         o_lin,
    output logic signed [hrc_pkg::COMP_W-1:0]        o_comp
);
    import hrc_pkg::*;

    localparam int unsigned QC_W = ACC_W - COMP_SH + 1;

    // stage 5
    logic                     r_v5;
    logic signed [TEMP_W-1:0] r_t5;
    logic signed [LIN_W-1:0]  r_lin5;
    logic signed [K_W-1:0]    r_k5;
    logic signed [K_W-1:0]    n_k5;

    // stage 6
    logic                     r_v6;
    logic signed [TEMP_W-1:0] r_t6;
    logic signed [LIN_W-1:0]  r_lin6;
    logic signed [ACC_W-1:0]  r_acc6;
    logic signed [ACC_W-1:0]  n_acc6;
    logic signed [TEMP_W:0]   tm;
    logic signed [PROD_W-1:0] prod;

    // stage 7
    logic                     r_v7;
    logic signed [TEMP_W-1:0] r_t7;
    logic signed [LIN_W-1:0]  r_lin7;
    logic signed [COMP_W-1:0] r_comp7;
    logic signed [COMP_W-1:0] n_comp7;
    logic                     neg;
    logic [ACC_W-1:0]         mag;
    logic [ACC_W-1:0]         mag_r;
    logic signed [QC_W-1:0]   q;

    always_comb begin
        n_k5 = K_W'(K_W'(i_res.lin) * K_W'(COEF_D)) + COEF_E256;
    end

    always_comb begin
        tm     = (TEMP_W + 1)'(r_t5) - TEMP_REF;
        prod   = PROD_W'(PROD_W'(tm) * PROD_W'(r_k5));
        n_acc6 = (ACC_W'(r_lin5) <<< COMP_SH) + ACC_W'(prod);
    end

    // round to nearest with ties away from zero, then saturate
    always_comb begin
        neg   = r_acc6[ACC_W-1];
        mag   = neg ? ACC_W'(-r_acc6) : ACC_W'(r_acc6);
        mag_r = (mag + (ACC_W'(1) << (COMP_SH - 1))) >> COMP_SH;
        q     = neg ? -$signed(QC_W'(mag_r)) : $signed(QC_W'(mag_r));
        if (q < QC_W'(COMP_MIN)) begin
            n_comp7 = COMP_MIN;
        end else if (q > QC_W'(COMP_MAX)) begin
            n_comp7 = COMP_MAX;
        end else begin
            n_comp7 = COMP_W'(q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else if (i_en) begin
            r_v5 <= i_res.valid;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t5    <= i_res.temp;
            r_lin5  <= i_res.lin;
            r_k5    <= n_k5;
            r_t6    <= r_t5;
            r_lin6  <= r_lin5;
            r_acc6  <= n_acc6;
            r_t7    <= r_t6;
            r_lin7  <= r_lin6;
            r_comp7 <= n_comp7;
        end
    end

    assign o_valid = r_v7;
    assign o_temp  = r_t7;
    assign o_lin   = r_lin7;
    assign o_comp  = r_comp7;

endmodule
`default_nettype wire

/* design/humidity_temp_raw_conversion_unit.sv */
// an input transfer passes through all seven stages into the output register
// throughput: one sample pair per cycle while the output is not stalled
// the pipeline holds as a whole while a finished result waits and m_tready is low
// synchronous active-low reset clears all valid bits; data registers are not reset
// top level of the humidity and temperature raw conversion pipeline
`default_nettype none
module humidity_temp_raw_conversion_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // temp_word [15:0], rh_word [31:16]
    input  wire logic [31:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // temp_x32 [14:0], rh_linear_x256 [32:15], rh_comp_x256 [51:33], zero [55:52]
    output logic [55:0]      m_tdata
);
    import hrc_pkg::*;

    logic                     en;
    t_lin_out                 lin_res;
    logic signed [TEMP_W-1:0] temp;
    logic signed [LIN_W-1:0]  lin;
    logic signed [COMP_W-1:0] comp;

    // every stage moves when the output register is free or being emptied
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    hrc_lin u_lin (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (s_tvalid),
        .i_temp_word (s_tdata[15:0]),
        .i_rh_word   (s_tdata[31:16]),
        .o_res       (lin_res)
    );

    hrc_comp u_comp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_res   (lin_res),
        .o_valid (m_tvalid),
        .o_temp  (temp),
        .o_lin   (lin),
        .o_comp  (comp)
    );

    assign m_tdata = {4'b0000, comp, lin, temp};

endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
// self-checking testbench for the humidity and temperature raw conversion unit
module testbench;

    localparam int unsigned TW = hrc_pkg::TEMP_W;
    localparam int unsigned LW = hrc_pkg::LIN_W;
    localparam int unsigned CW = hrc_pkg::COMP_W;

    // coefficients with 24 fractional bits
    localparam longint K_SQ   = 65934;
    localparam longint K_LIN  = 6724308;
    localparam longint K_OFS  = 80268912;
    localparam longint K_TSLP = 39762;
    localparam longint K_TOFS = 3310145;

    localparam longint LIN_LO  = -4096;
    localparam longint LIN_HI  = 131071;
    localparam longint COMP_LO = -16384;
    localparam longint COMP_HI = 262143;

    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned DRAIN_LIMIT  = 20000;

    typedef struct packed {
        logic signed [TW-1:0] temp;
        logic signed [LW-1:0] lin;
        logic signed [CW-1:0] comp;
    } humid_result_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    // temp_word [15:0], rh_word [31:16]
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    // temp_x32 [14:0], rh_linear_x256 [32:15], rh_comp_x256 [51:33], zero [55:52]
    logic [55:0] m_tdata;

    humid_result_t pending_conversions[$];
    int unsigned   fail_count;
    bit            jitter_on;

    humidity_temp_raw_conversion_unit uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // divide by 2^sh, nearest, ties away from zero
    function automatic longint round_near(input longint x, input int unsigned sh);
        longint half;
        half = longint'(1) << (sh - 1);
        if (x >= 0) begin
            return (x + half) >>> sh;
        end
        return -((-x + half) >>> sh);
    endfunction

    function automatic longint saturate(input longint x, input longint lo, input longint hi);
        if (x < lo) begin
            return lo;
        end
        if (x > hi) begin
            return hi;
        end
        return x;
    endfunction

    function automatic humid_result_t convert_raw(input logic [15:0] temp_word,
                                                  input logic [15:0] rh_word);
        longint t32;
        longint r16;
        longint lin_fine;
        longint lin;
        longint acc;
        longint comp;
        humid_result_t res;
        t32 = temp_word[15:2];
        t32 = t32 - 1600;
        r16 = rh_word[15:4];
        r16 = r16 - 384;
        // linearized humidity with 32 fractional bits
        lin_fine = r16 * 268435456 + K_SQ * r16 * r16 - 16 * K_LIN * r16 + 256 * K_OFS;
        lin = saturate(round_near(lin_fine, 24), LIN_LO, LIN_HI);
        // compensation with 37 fractional bits, temperature referenced to 30 degC
        acc = lin * 536870912 + (t32 - 960) * (K_TSLP * lin + 256 * K_TOFS);
        comp = saturate(round_near(acc, 29), COMP_LO, COMP_HI);
        res.temp = t32[TW-1:0];
        res.lin  = lin[LW-1:0];
        res.comp = comp[CW-1:0];
        return res;
    endfunction

    // both sides of the stream observed at the rising edge
    always @(posedge i_clk) begin
        humid_result_t exp_res;
        if (i_rst_n) begin
            if (s_tvalid && s_tready) begin
                pending_conversions.push_back(convert_raw(s_tdata[15:0], s_tdata[31:16]));
            end
            if (m_tvalid && m_tready) begin
                if (pending_conversions.size() == 0) begin
                    $error("result transfer with nothing pending: %h", m_tdata);
                    fail_count++;
                end else begin
                    exp_res = pending_conversions.pop_front();
                    if (m_tdata[14:0] !== exp_res.temp) begin
                        $error("temp_x32 expected %0d actual %0d",
                               exp_res.temp, $signed(m_tdata[14:0]));
                        fail_count++;
                    end
                    if (m_tdata[32:15] !== exp_res.lin) begin
                        $error("rh_linear_x256 expected %0d actual %0d",
                               exp_res.lin, $signed(m_tdata[32:15]));
                        fail_count++;
                    end
                    if (m_tdata[51:33] !== exp_res.comp) begin
                        $error("rh_comp_x256 expected %0d actual %0d",
                               exp_res.comp, $signed(m_tdata[51:33]));
                        fail_count++;
                    end
                    if (m_tdata[55:52] !== 4'd0) begin
                        $error("zero padding expected 0 actual %h", m_tdata[55:52]);
                        fail_count++;
                    end
                end
            end
        end
    end

    // receiver: random hold-off before each result transfer while jitter is on
    initial begin
        int unsigned stall;
        m_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = jitter_on ? $urandom_range(0, 3) : 0;
            if (stall > 0) begin
                @(negedge i_clk);
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (!(m_tvalid && m_tready)) @(posedge i_clk);
        end
    end

    task automatic send_pair(input logic [15:0] temp_word, input logic [15:0] rh_word);
        int unsigned gap;
        gap = jitter_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {rh_word, temp_word};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    task automatic wait_all_done();
        int unsigned waited;
        waited = 0;
        while (pending_conversions.size() != 0) begin
            @(posedge i_clk);
            waited++;
            if (waited > DRAIN_LIMIT) begin
                $display("humidity_temp_raw_conversion_unit test failed");
                $finish;
            end
        end
    endtask

    task automatic test_directed_extremes();
        jitter_on = 1'b1;
        send_pair(16'h0000, 16'h0000);
        send_pair(16'hFFFF, 16'hFFFF);
        send_pair(16'h0000, 16'hFFFF);
        send_pair(16'hFFFF, 16'h0000);
        // 30 degC reference point, compensation term vanishes
        send_pair(16'd10240, 16'h7A30);
        // humidity below zero and far above 100 percent
        send_pair(16'h6680, 16'h0010);
        send_pair(16'h6680, 16'h1800);
        send_pair(16'h6680, 16'hF000);
        send_pair(16'h5555, 16'hAAAA);
        send_pair(16'hAAAA, 16'h5555);
        send_pair(16'h8000, 16'h8000);
        send_pair(16'h7FFF, 16'h7FFF);
    endtask

    task automatic test_ignored_low_bits();
        jitter_on = 1'b0;
        send_pair(16'h0003, 16'h000F);
        send_pair(16'h0000, 16'h0000);
        send_pair(16'h4A01, 16'h6C07);
        send_pair(16'h4A02, 16'h6C08);
        send_pair(16'h4A03, 16'h6C0F);
        send_pair(16'h4A00, 16'h6C00);
        send_pair(16'hFFFC, 16'hFFF0);
        send_pair(16'hFFFD, 16'hFFF1);
    endtask

    task automatic test_random_stream();
        jitter_on = 1'b1;
        repeat (900) begin
            send_pair(16'($urandom), 16'($urandom));
        end
    endtask

    task automatic test_back_to_back();
        jitter_on = 1'b0;
        repeat (150) begin
            send_pair(16'($urandom), 16'($urandom));
        end
    endtask

    // sender holds off until the pipeline is empty between bursts
    task automatic test_drain_pause();
        jitter_on = 1'b1;
        repeat (5) begin
            repeat ($urandom_range(10, 25)) begin
                send_pair(16'($urandom), 16'($urandom));
            end
            @(negedge i_clk);
            s_tvalid <= 1'b0;
            wait_all_done();
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        fail_count = 0;
        jitter_on  = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_extremes();
        test_ignored_low_bits();
        test_random_stream();
        test_drain_pause();
        test_back_to_back();

        @(negedge i_clk);
        s_tvalid <= 1'b0;
        wait_all_done();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_conversions.size() == 0) begin
            $display("humidity_temp_raw_conversion_unit test passed");
        end else begin
            $display("humidity_temp_raw_conversion_unit test failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("humidity_temp_raw_conversion_unit test failed");
        $finish;
    end

endmodule

/* sim.f */
design/hrc_pkg.sv
design/hrc_lin.sv
design/hrc_comp.sv
design/humidity_temp_raw_conversion_unit.sv
tb/sv/testbench.sv
